@@ src/relay_matrix_interlock_assert.svh @@
// Assertion macros shared by the relay matrix interlock RTL
`ifndef RELAY_MATRIX_INTERLOCK_ASSERT_SVH
`define RELAY_MATRIX_INTERLOCK_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define RMI_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("relay_matrix_interlock: check failed");

// Next-cycle implication, checked outside reset
`define RMI_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("relay_matrix_interlock: check failed");

`endif

@@ src/rmi_pkg.sv @@
// Types, constants and command tables for the relay matrix interlock
package rmi_pkg;

  localparam int MAX_BATCH_DEF = 10;
  localparam int NUM_CODES     = 68;
  localparam int NUM_RELAYS    = 34;
  localparam int CNT_W         = 4;

  // Special request codes
  localparam logic [6:0] CODE_PKTT     = 7'd55;
  localparam logic [6:0] CODE_NKTT     = 7'd61;
  localparam logic [6:0] CODE_LIMIT    = 7'd68;
  localparam logic [6:0] KN_OPEN_BASE  = 7'd32;
  localparam logic [6:0] KN_CLOSE_BASE = 7'd38;
  localparam logic [6:0] KI_OPEN_BASE  = 7'd44;
  localparam logic [6:0] KI_CLOSE_BASE = 7'd48;
  localparam int         KTT_BIT       = 29;

  // Relays on after reset: KN6 and KI4
  localparam logic [NUM_RELAYS-1:0] RELAY_DEFAULT =
    (NUM_RELAYS'(1) << 21) | (NUM_RELAYS'(1) << 25);

  typedef enum logic [1:0] {
    MODE_SWITCH = 2'd0,
    MODE_BATCH  = 2'd1,
    MODE_RESET  = 2'd2,
    MODE_NOP    = 2'd3
  } mode_t;

  // Command byte per request code
  localparam logic [6:0] CMD_BYTE [NUM_CODES] = '{
    7'h16, 7'h14, 7'h26, 7'h24, 7'h01, 7'h00, 7'h31, 7'h11, 7'h32, 7'h17,
    7'h1f, 7'h1d, 7'h2f, 7'h2d, 7'h08, 7'h09, 7'h38, 7'h18, 7'h3b, 7'h1e,
    7'h15, 7'h13, 7'h27, 7'h25, 7'h12, 7'h10,
    7'h1c, 7'h1a, 7'h2e, 7'h2c, 7'h1b, 7'h19,
    7'h06, 7'h07, 7'h04, 7'h05, 7'h02, 7'h03,
    7'h0f, 7'h0e, 7'h0d, 7'h0c, 7'h0b, 7'h0a,
    7'h37, 7'h36, 7'h35, 7'h34,
    7'h3e, 7'h3f, 7'h3c, 7'h3d,
    7'h23, 7'h20, 7'h21, 7'h33, 7'h22, 7'h30,
    7'h2a, 7'h29, 7'h28, 7'h3a, 7'h2b, 7'h39,
    7'h41, 7'h40, 7'h43, 7'h42
  };

  // Relay bit per request code
  localparam logic [5:0] TARGET_BIT [NUM_CODES] = '{
    6'd0,  6'd1,  6'd2,  6'd3,  6'd4,  6'd5,  6'd6,  6'd7,  6'd8,  6'd9,
    6'd0,  6'd1,  6'd2,  6'd3,  6'd4,  6'd5,  6'd6,  6'd7,  6'd8,  6'd9,
    6'd10, 6'd11, 6'd12, 6'd13, 6'd14, 6'd15,
    6'd10, 6'd11, 6'd12, 6'd13, 6'd14, 6'd15,
    6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21,
    6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21,
    6'd22, 6'd23, 6'd24, 6'd25,
    6'd22, 6'd23, 6'd24, 6'd25,
    6'd26, 6'd27, 6'd28, 6'd29, 6'd30, 6'd31,
    6'd26, 6'd27, 6'd28, 6'd29, 6'd30, 6'd31,
    6'd32, 6'd32, 6'd33, 6'd33
  };

  // Direction per request code: 1 closes the relay
  localparam logic TURNS_ON [NUM_CODES] = '{
    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
    1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1,
    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
    1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1,
    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
    1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1,
    1'b0, 1'b0, 1'b0, 1'b0,
    1'b1, 1'b1, 1'b1, 1'b1,
    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
    1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1,
    1'b0, 1'b1, 1'b0, 1'b1
  };

endpackage

@@ src/relay_matrix_interlock.sv @@
// Relay matrix interlock: request decode, group interlock and batch limit
//
//  channel | dir | signals                                  | contents
//  in      | in  | in_tvalid/in_tready/in_tdata/in_tuser    | switch code, mode
//  out     | out | out_tvalid/out_tready/out_tdata/out_tlast | command byte, last flag
//  cfg     | in  | cfg_valid/cfg_ready/cfg_data             | enable bit
//
// A request is captured in the input register and decoded there against the
// current relay state; the state updates as its bytes load the result stage.
// A request giving no byte loads nothing; one giving one byte fills one slot,
// and a group close giving two bytes fills both slots of the result stage.
// rst_n (synchronous) restores the default relays, clears the batch and
// disables the device. Output stalls back up through the result stage only.
module relay_matrix_interlock
  import rmi_pkg::*;
#(
  parameter int MAX_BATCH = MAX_BATCH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [6:0] switch_code, [7] zero
  input  logic [1:0] in_tuser,   // [1:0] mode
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [6:0] relay_code, [7] zero
  output logic       out_tlast,  // last_of_run
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data    // enable
);

  // Input register
  logic       in_valid_r, in_valid_nxt;
  logic [1:0] in_mode_r;
  logic [6:0] in_code_r;

  // Device state
  logic                  enable_r, enable_nxt;
  logic [NUM_RELAYS-1:0] relay_on_r, relay_on_nxt;
  logic [CNT_W-1:0]      batch_cnt_r, batch_cnt_nxt;
  logic                  batch_closed_r, batch_closed_nxt;

  // Two-slot result stage
  logic [1:0] res_cnt_r, res_cnt_nxt;
  logic [6:0] res_code0_r, res_code0_nxt, res_code1_r, res_code1_nxt;
  logic       res_last0_r, res_last0_nxt, res_last1_r, res_last1_nxt;

  // Decode
  mode_t      mode;
  logic [6:0] pos;
  logic       active, code_bad, refused, grp_kn, grp_ki;
  logic       pre_hit;
  logic [5:0] pre_bit;
  logic [6:0] pre_byte;
  logic [5:0] tgt_bit;
  logic       no_change, fits, emit;
  logic [CNT_W:0] cnt_sum;
  logic       out_fire, res_room, proc_go;

  assign mode     = mode_t'(in_mode_r);
  assign out_fire = out_tvalid && out_tready;
  assign cfg_ready = 1'b1;

  // Request decode against the current relay state
  always_comb begin
    pos = in_code_r;
    if (in_code_r == CODE_NKTT && relay_on_r[KTT_BIT]) begin
      pos = CODE_PKTT;
    end
    active   = in_valid_r && mode == MODE_SWITCH && enable_r && !batch_closed_r;
    code_bad = in_code_r >= CODE_LIMIT;
    refused  = (pos >= KN_OPEN_BASE && pos < KN_CLOSE_BASE) ||
               (pos >= KI_OPEN_BASE && pos < KI_CLOSE_BASE);
    grp_kn   = pos >= KN_CLOSE_BASE && pos < KI_OPEN_BASE;
    grp_ki   = pos >= KI_CLOSE_BASE && pos < KI_CLOSE_BASE + 7'd4;
    tgt_bit  = code_bad ? 6'd0 : TARGET_BIT[pos];
    no_change = code_bad || (relay_on_r[tgt_bit] == TURNS_ON[pos]);

    // Lowest closed member of the group being closed into
    pre_hit  = 1'b0;
    pre_bit  = 6'd0;
    pre_byte = 7'd0;
    if (grp_kn) begin
      for (int i = 5; i >= 0; i--) begin
        if (relay_on_r[16 + i]) begin
          pre_hit  = 1'b1;
          pre_bit  = 6'(16 + i);
          pre_byte = CMD_BYTE[KN_OPEN_BASE + 7'(i)];
        end
      end
    end else if (grp_ki) begin
      for (int i = 3; i >= 0; i--) begin
        if (relay_on_r[22 + i]) begin
          pre_hit  = 1'b1;
          pre_bit  = 6'(22 + i);
          pre_byte = CMD_BYTE[KI_OPEN_BASE + 7'(i)];
        end
      end
    end

    cnt_sum = {1'b0, batch_cnt_r} + (pre_hit ? (CNT_W+1)'(2) : (CNT_W+1)'(1));
    fits    = cnt_sum <= (CNT_W+1)'(MAX_BATCH);
    emit    = active && !code_bad && in_code_r != CODE_PKTT && !refused &&
              !no_change && fits;
  end

  // Result stage takes a new run once it is empty or draining its last byte
  assign res_room  = res_cnt_r == 2'd0 || (res_cnt_r == 2'd1 && out_tready);
  assign proc_go   = in_valid_r && (!emit || res_room);
  assign in_tready = !in_valid_r || proc_go;

  // Input register next state
  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_tvalid && in_tready) begin
      in_valid_nxt = 1'b1;
    end else if (proc_go) begin
      in_valid_nxt = 1'b0;
    end
  end

  // Relay, batch and enable next state
  always_comb begin
    enable_nxt       = enable_r;
    relay_on_nxt     = relay_on_r;
    batch_cnt_nxt    = batch_cnt_r;
    batch_closed_nxt = batch_closed_r;
    if (cfg_valid && cfg_ready) begin
      enable_nxt = cfg_data;
    end
    if (proc_go) begin
      case (mode)
        MODE_BATCH: begin
          batch_cnt_nxt    = '0;
          batch_closed_nxt = 1'b0;
        end
        MODE_RESET: begin
          if (enable_r) relay_on_nxt = RELAY_DEFAULT;
        end
        MODE_SWITCH: begin
          if (active) begin
            if (code_bad) begin
              batch_closed_nxt = 1'b1;
            end else if (emit) begin
              if (pre_hit) relay_on_nxt[pre_bit] = 1'b0;
              relay_on_nxt[tgt_bit] = !relay_on_r[tgt_bit];
              batch_cnt_nxt = cnt_sum[CNT_W-1:0];
              if (cnt_sum >= (CNT_W+1)'(MAX_BATCH)) batch_closed_nxt = 1'b1;
            end else if (in_code_r != CODE_PKTT && !refused && !no_change) begin
              // Batch has no room for this run
              batch_closed_nxt = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Result stage: pop on handshake, load a fresh run when one is emitted
  always_comb begin
    res_cnt_nxt   = res_cnt_r;
    res_code0_nxt = res_code0_r;
    res_last0_nxt = res_last0_r;
    res_code1_nxt = res_code1_r;
    res_last1_nxt = res_last1_r;
    if (out_fire) begin
      res_cnt_nxt   = res_cnt_r - 2'd1;
      res_code0_nxt = res_code1_r;
      res_last0_nxt = res_last1_r;
    end
    if (proc_go && emit) begin
      if (pre_hit) begin
        res_cnt_nxt   = 2'd2;
        res_code0_nxt = pre_byte;
        res_last0_nxt = 1'b0;
        res_code1_nxt = CMD_BYTE[pos];
        res_last1_nxt = 1'b1;
      end else begin
        res_cnt_nxt   = 2'd1;
        res_code0_nxt = CMD_BYTE[pos];
        res_last0_nxt = 1'b1;
      end
    end
  end

  assign out_tvalid = res_cnt_r != 2'd0;
  assign out_tdata  = {1'b0, res_code0_r};
  assign out_tlast  = res_last0_r;

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r     <= 1'b0;
      enable_r       <= 1'b0;
      relay_on_r     <= RELAY_DEFAULT;
      batch_cnt_r    <= '0;
      batch_closed_r <= 1'b0;
      res_cnt_r      <= 2'd0;
    end else begin
      in_valid_r     <= in_valid_nxt;
      enable_r       <= enable_nxt;
      relay_on_r     <= relay_on_nxt;
      batch_cnt_r    <= batch_cnt_nxt;
      batch_closed_r <= batch_closed_nxt;
      res_cnt_r      <= res_cnt_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_mode_r <= in_tuser;
      in_code_r <= in_tdata[6:0];
    end
    res_code0_r <= res_code0_nxt;
    res_last0_r <= res_last0_nxt;
    res_code1_r <= res_code1_nxt;
    res_last1_r <= res_last1_nxt;
  end

  // Checks
  `include "relay_matrix_interlock_assert.svh"

  `RMI_ASSERT_IMP(a_batch_bound, clk, rst_n, 1'b1, batch_cnt_r <= CNT_W'(MAX_BATCH))
  `RMI_ASSERT_IMP(a_kn_onehot, clk, rst_n, 1'b1, $onehot0(relay_on_r[21:16]))
  `RMI_ASSERT_IMP(a_ki_onehot, clk, rst_n, 1'b1, $onehot0(relay_on_r[25:22]))
  `RMI_ASSERT_IMP(a_pair_order, clk, rst_n, res_cnt_r == 2'd2, !res_last0_r && res_last1_r)
  `RMI_ASSERT_NXT(a_emit_shows, clk, rst_n, proc_go && emit, out_tvalid && out_tlast == !$past(pre_hit))

endmodule

@@ test/tb_relay_matrix_interlock.sv @@
// Testbench for relay_matrix_interlock: predicted command bytes against the stream output
`timescale 1ns / 100ps

module tb_relay_matrix_interlock
  import rmi_pkg::*;
();

  localparam int BATCH_LIMIT  = MAX_BATCH_DEF;
  localparam int KN_FIRST_BIT = 16;
  localparam int KI_FIRST_BIT = 22;
  localparam int SETTLE_CYC   = 8;

  typedef struct {
    mode_t      mode;
    logic [6:0] code;
  } switch_req_t;

  typedef struct packed {
    logic [6:0] code;
    logic       last;
  } relay_cmd_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic       out_tlast;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_data = 1'b0;

  // Requests waiting for the driver, command bytes waiting for the output
  switch_req_t pending_requests[$];
  relay_cmd_t  expected_bytes[$];

  // Shadow of the interlock state
  logic [NUM_RELAYS-1:0] relay_state;
  logic [CNT_W-1:0]      batch_used;
  logic                  batch_shut;
  logic                  dev_enabled;

  int          fail_count = 0;
  int          in_gap = 0;
  int          out_hold = 0;
  bit          in_calm = 1'b0;
  bit          out_calm = 1'b0;
  switch_req_t next_req;
  relay_cmd_t  want;

  relay_matrix_interlock DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // Idle length: mostly none or short, now and then long
  function automatic int gap_len(input bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  // Works out the command bytes one request causes and updates the shadow state
  function automatic void predict_request(input mode_t mode, input logic [6:0] code);
    logic [6:0] pos;
    logic [5:0] bit_idx;
    int         pre_bit;
    logic [6:0] pre_byte;
    int         need;
    pre_bit = -1;
    pre_byte = '0;
    case (mode)
      MODE_BATCH: begin
        batch_used = '0;
        batch_shut = 1'b0;
        return;
      end
      MODE_RESET: begin
        if (dev_enabled) relay_state = RELAY_DEFAULT;
        return;
      end
      MODE_NOP: return;
      default: ;
    endcase
    if (!dev_enabled || batch_shut) return;
    // invalid code ends the batch
    if (code >= CODE_LIMIT) begin
      batch_shut = 1'b1;
      return;
    end
    pos = code;
    if (pos == CODE_PKTT) return;
    if (pos == CODE_NKTT) pos = relay_state[KTT_BIT] ? CODE_PKTT : CODE_NKTT;
    // manual opens in the one-hot groups are refused
    if ((pos >= KN_OPEN_BASE && pos < KN_OPEN_BASE + 6) ||
        (pos >= KI_OPEN_BASE && pos < KI_OPEN_BASE + 4)) return;
    // group close: the member that is on opens first
    if (pos >= KI_CLOSE_BASE && pos < KI_CLOSE_BASE + 4) begin
      if (relay_state[TARGET_BIT[pos]]) return;
      for (int i = 0; i < 4; i++) begin
        if (pre_bit < 0 && relay_state[KI_FIRST_BIT + i]) begin
          pre_bit = KI_FIRST_BIT + i;
          pre_byte = CMD_BYTE[KI_OPEN_BASE + i];
        end
      end
    end else if (pos >= KN_CLOSE_BASE && pos < KN_CLOSE_BASE + 6) begin
      if (relay_state[TARGET_BIT[pos]]) return;
      for (int i = 0; i < 6; i++) begin
        if (pre_bit < 0 && relay_state[KN_FIRST_BIT + i]) begin
          pre_bit = KN_FIRST_BIT + i;
          pre_byte = CMD_BYTE[KN_OPEN_BASE + i];
        end
      end
    end
    bit_idx = TARGET_BIT[pos];
    if (relay_state[bit_idx] == TURNS_ON[pos]) return;
    need = (pre_bit >= 0) ? 2 : 1;
    // not enough room left in the batch
    if (int'(batch_used) + need > BATCH_LIMIT) begin
      batch_shut = 1'b1;
      return;
    end
    if (pre_bit >= 0) begin
      relay_state[pre_bit] = 1'b0;
      expected_bytes.push_back('{code: pre_byte, last: 1'b0});
    end
    relay_state[bit_idx] = ~relay_state[bit_idx];
    expected_bytes.push_back('{code: CMD_BYTE[pos], last: 1'b1});
    batch_used = batch_used + CNT_W'(need);
    if (int'(batch_used) >= BATCH_LIMIT) batch_shut = 1'b1;
  endfunction

  // Request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_gap = 0;
    end else if (!in_tvalid || in_tready) begin
      if (in_gap > 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (pending_requests.size() > 0) begin
        next_req = pending_requests.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= {1'b0, next_req.code};
        in_tuser <= next_req.mode;
        in_gap = gap_len(in_calm);
        if ($urandom_range(0, 49) == 0) in_calm = !in_calm;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Output back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_hold = 0;
    end else if (out_hold > 0) begin
      out_hold--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      out_hold = gap_len(out_calm);
      if ($urandom_range(0, 63) == 0) out_calm = !out_calm;
    end
  end

  // Monitor: check output bytes, then predict from accepted requests
  always @(posedge clk) begin
    if (!rst_n) begin
      relay_state = RELAY_DEFAULT;
      batch_used = '0;
      batch_shut = 1'b0;
      dev_enabled = 1'b0;
      expected_bytes.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_bytes.size() == 0) begin
          $display("%0t: unexpected command byte, expected none, actual %02h last %0b",
                   $time, out_tdata, out_tlast);
          fail_count++;
        end else begin
          want = expected_bytes.pop_front();
          if (out_tdata !== {1'b0, want.code}) begin
            $display("%0t: relay_code mismatch, expected %02h, actual %02h",
                     $time, {1'b0, want.code}, out_tdata);
            fail_count++;
          end
          if (out_tlast !== want.last) begin
            $display("%0t: last_of_run mismatch, expected %0b, actual %0b",
                     $time, want.last, out_tlast);
            fail_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) dev_enabled = cfg_data;
      if (in_tvalid && in_tready) predict_request(mode_t'(in_tuser), in_tdata[6:0]);
    end
  end

  task automatic add_req(input mode_t mode, input logic [6:0] code);
    pending_requests.push_back('{mode: mode, code: code});
  endtask

  // Mostly switch requests with occasional batch starts, resets and noise
  task automatic add_random(input int count);
    int r;
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < 78) add_req(MODE_SWITCH, 7'($urandom_range(0, NUM_CODES - 1)));
      else if (r < 88) add_req(MODE_BATCH, 7'($urandom_range(0, 127)));
      else if (r < 92) add_req(MODE_RESET, 7'($urandom_range(0, 127)));
      else if (r < 95) add_req(MODE_NOP, 7'($urandom_range(0, 127)));
      else add_req(MODE_SWITCH, 7'($urandom_range(NUM_CODES, 127)));
    end
  endtask

  // Wait until every request is in and every byte is out, then let the pipe settle;
  // sampled on the falling edge so the driver's updates have landed
  task automatic drain();
    int waited;
    waited = 0;
    do begin
      @(negedge clk);
      waited++;
    end while ((pending_requests.size() != 0 || in_tvalid || expected_bytes.size() != 0)
               && waited < 200000);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_enable(input logic value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // disabled device: switch requests and relay resets do nothing
    write_enable(1'b0);
    add_req(MODE_SWITCH, 7'd10);
    add_req(MODE_RESET, 7'd0);
    add_req(MODE_BATCH, 7'd127);
    add_req(MODE_SWITCH, 7'd38);
    drain();

    write_enable(1'b1);
    add_req(MODE_BATCH, 7'd0);
    add_req(MODE_SWITCH, 7'd0);            // already open
    add_req(MODE_SWITCH, 7'd10);
    add_req(MODE_SWITCH, 7'd0);
    add_req(MODE_SWITCH, CODE_PKTT);       // ignored
    add_req(MODE_SWITCH, CODE_NKTT);       // KTT on
    add_req(MODE_SWITCH, CODE_NKTT);       // KTT off
    add_req(MODE_SWITCH, KN_CLOSE_BASE);   // opens KN6 first
    add_req(MODE_SWITCH, KN_OPEN_BASE);    // refused
    add_req(MODE_SWITCH, KI_CLOSE_BASE);   // opens KI4 first
    add_req(MODE_SWITCH, 7'd64);
    add_req(MODE_SWITCH, 7'd65);
    add_req(MODE_SWITCH, 7'd42);           // two bytes, one slot left
    add_req(MODE_SWITCH, 7'd67);           // batch closed
    add_req(MODE_BATCH, 7'd0);
    add_req(MODE_RESET, 7'd127);
    add_req(MODE_NOP, 7'd127);
    add_req(MODE_SWITCH, 7'd127);          // invalid, ends batch
    add_req(MODE_SWITCH, 7'd10);
    add_req(MODE_BATCH, 7'd0);
    add_req(MODE_SWITCH, CODE_LIMIT);
    add_req(MODE_BATCH, 7'd0);
    add_req(MODE_SWITCH, 7'd67);
    add_req(MODE_SWITCH, 7'd66);
    drain();

    add_random(900);
    drain();
    write_enable(1'b0);
    add_random(100);
    drain();
    write_enable(1'b1);
    add_random(1000);
    drain();
    repeat (20) @(posedge clk);

    if (expected_bytes.size() != 0) begin
      $display("%0t: %0d command bytes never arrived", $time, expected_bytes.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("** relay_matrix_interlock: PASSED **");
    end else begin
      $display("** relay_matrix_interlock: FAILED **");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("%0t: timeout", $time);
    $display("** relay_matrix_interlock: FAILED **");
    $finish;
  end

endmodule
